/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; include this header by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define HB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition that must hold on every clock edge outside reset.
`define HB_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

/* rtl/core/hb_pkg.sv */
// Shared constants, types and the Q.32 multiply for the hextile blend weights block.
// No dependencies.
package hb_pkg;

    // Internal fixed point: unsigned Q.32, one equals 2^32.
    localparam int QB = 32;
    localparam int PW = 17;
    localparam logic [32:0] QONE  = 33'h1_0000_0000;
    localparam logic [32:0] QHALF = 33'h0_8000_0000;
    localparam logic [32:0] R_LO  = 33'd4294967;
    localparam logic [32:0] R_HI  = 33'd4290672329;

    // Pipeline depths: divider, and request to result strobe.
    localparam int DIV_LAT = 33;
    localparam int HB_LAT  = 109;

    typedef logic [32:0] t_q;
    typedef logic [PW-1:0] t_port;

    // Truncated product of two Q.32 values that are both at most one.
    function automatic t_q mulq(input t_q a, input t_q b);
        logic [63:0] prod;
        prod = a[31:0] * b[31:0];
        if (a >= QONE) begin
            return b;
        end else if (b >= QONE) begin
            return a;
        end
        return {1'b0, prod[63:32]};
    endfunction

endpackage

/* rtl/core/hextile_blend_weights.sv */
// Hextile blend weights: three lanes of weight product, normalize, gain, normalize.
// One request per cycle, o_busy stays low; a falloff of one half skips the gain path.
// The depth is set by the three 33-stage dividers and the five-stage power chain.
// Synchronous active-low reset clears the pipeline valids and sets falloff to one half.
// Depends on hb_pkg, hb_wprod, hb_div, hb_gain and hb_delay.
module hextile_blend_weights #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  hb_pkg::t_port i_lum_weight_a,
    input  hb_pkg::t_port i_lum_weight_b,
    input  hb_pkg::t_port i_lum_weight_c,
    input  hb_pkg::t_port i_tile_weight_a,
    input  hb_pkg::t_port i_tile_weight_b,
    input  hb_pkg::t_port i_tile_weight_c,
    input  logic          i_falloff_we,
    input  hb_pkg::t_port i_falloff,
    output logic          o_done,
    output hb_pkg::t_port o_blend_a,
    output hb_pkg::t_port o_blend_b,
    output hb_pkg::t_port o_blend_c,
    output logic          o_degenerate
);
    import hb_pkg::*;

    localparam int SH = QB - FRAC_BITS;
    localparam t_port HALF_P = t_port'(1 << (FRAC_BITS - 1));
    localparam logic [33:0] ONE_P = 34'(1) << FRAC_BITS;
    localparam logic [33:0] RND = 34'(1) << (SH - 1);
    localparam int D_BYP = 2 * DIV_LAT + 2;
    localparam int D_Z1 = 3 * DIV_LAT + 2;

    t_port       r_falloff;
    t_q          r_r;
    logic [HB_LAT-1:0] r_vld;
    t_q          r_lq [3];
    t_q          r_tq [3];
    t_port       n_lum [3];
    t_port       n_tile [3];
    t_q          n_w [3];
    t_q          r_w1 [3];
    logic [33:0] r_s1, r_s2;
    logic        r_z1, r_z2;
    t_q          n_n1 [3];
    t_q          n_g [3];
    t_q          r_g [3];
    t_q          n_n2 [3];
    t_q          n_byp [3];
    logic        n_z1d, n_z2d;
    logic [47:0] n_rw;
    t_q          n_fin [3];
    logic [33:0] n_rnd [3];
    t_port       n_out [3];
    logic        n_deg;

    // Port value to Q.32, saturated to one.
    function automatic t_q to_q(input t_port p);
        logic [47:0] v;
        v = 48'(p) << SH;
        return (v > 48'(QONE)) ? QONE : v[32:0];
    endfunction

    assign o_busy = 1'b0;

    // Falloff register and its clamped contrast.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_falloff <= HALF_P;
        end else if (i_falloff_we) begin
            r_falloff <= i_falloff;
        end
    end

    always_comb begin
        n_rw = 48'(r_falloff) << SH;
    end

    always_ff @(posedge i_clk) begin
        if (n_rw < 48'(R_LO)) begin
            r_r <= R_LO;
        end else if (n_rw > 48'(R_HI)) begin
            r_r <= R_HI;
        end else begin
            r_r <= n_rw[32:0];
        end
    end

    // Valid line that follows each request through the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[HB_LAT-2:0], i_start & ~o_busy};
        end
    end

    assign n_lum  = '{i_lum_weight_a, i_lum_weight_b, i_lum_weight_c};
    assign n_tile = '{i_tile_weight_a, i_tile_weight_b, i_tile_weight_c};

    // Per-lane input conversion, weight product, both normalizes, gain and bypass delay.
    for (genvar i = 0; i < 3; i++) begin : g_lane
        always_ff @(posedge i_clk) begin
            r_lq[i] <= to_q(n_lum[i]);
            r_tq[i] <= to_q(n_tile[i]);
        end

        hb_wprod u_wprod (
            .i_clk  (i_clk),
            .i_lum  (r_lq[i]),
            .i_tile (r_tq[i]),
            .o_w    (n_w[i])
        );

        hb_div u_div1 (
            .i_clk (i_clk),
            .i_num ({1'b0, r_w1[i]}),
            .i_den (r_s1),
            .o_q   (n_n1[i])
        );

        hb_gain u_gain (
            .i_clk (i_clk),
            .i_x   (n_n1[i]),
            .i_r   (r_r),
            .o_g   (n_g[i])
        );

        hb_div u_div2 (
            .i_clk (i_clk),
            .i_num ({1'b0, r_g[i]}),
            .i_den (r_s2),
            .o_q   (n_n2[i])
        );

        hb_delay #(.WIDTH(33), .DEPTH(D_BYP)) u_byp (
            .i_clk (i_clk),
            .i_d   (n_n1[i]),
            .o_q   (n_byp[i])
        );
    end

    // Merge the lanes: first and second sums with their zero flags.
    always_ff @(posedge i_clk) begin
        r_w1 <= n_w;
        r_s1 <= 34'(n_w[0]) + 34'(n_w[1]) + 34'(n_w[2]);
        r_z1 <= (n_w[0] == '0) && (n_w[1] == '0) && (n_w[2] == '0);
        r_g  <= n_g;
        r_s2 <= 34'(n_g[0]) + 34'(n_g[1]) + 34'(n_g[2]);
        r_z2 <= (n_g[0] == '0) && (n_g[1] == '0) && (n_g[2] == '0);
    end

    hb_delay #(.WIDTH(1), .DEPTH(D_Z1)) u_z1 (
        .i_clk (i_clk),
        .i_d   (r_z1),
        .o_q   (n_z1d)
    );

    hb_delay #(.WIDTH(1), .DEPTH(DIV_LAT)) u_z2 (
        .i_clk (i_clk),
        .i_d   (r_z2),
        .o_q   (n_z2d)
    );

    // Bypass select, rounding to the port format and the degenerate case.
    always_comb begin
        n_deg = n_z1d || ((r_falloff != HALF_P) && n_z2d);
        for (int i = 0; i < 3; i++) begin
            n_fin[i] = (r_falloff == HALF_P) ? n_byp[i] : n_n2[i];
            n_rnd[i] = (34'(n_fin[i]) + RND) >> SH;
            if (n_rnd[i] > ONE_P) begin
                n_rnd[i] = ONE_P;
            end
            n_out[i] = n_deg ? '0 : n_rnd[i][PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_blend_a    <= n_out[0];
        o_blend_b    <= n_out[1];
        o_blend_c    <= n_out[2];
        o_degenerate <= n_deg;
    end

    assign o_done = r_vld[HB_LAT-1];
endmodule

/* rtl/core/hb_delay.sv */
// Fixed-depth shift line for payload that waits beside the arithmetic pipeline.
// No dependencies.
module hb_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    // Shift one place per cycle.
    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

/* rtl/core/hb_div.sv */
// Pipelined restoring divider, one quotient bit per stage: floor(num*2^32/den), saturated.
// Depends on hb_pkg.
module hb_div (
    input  logic        i_clk,
    input  logic [33:0] i_num,
    input  logic [33:0] i_den,
    output hb_pkg::t_q  o_q
);
    import hb_pkg::*;

    logic [34:0] r_rem [QB+1];
    logic [33:0] r_den [QB+1];
    logic [31:0] r_q   [QB+1];
    logic        r_sat [QB+1];

    // Capture operands; a numerator at or above the denominator saturates to one.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= {1'b0, i_num};
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_sat[0] <= (i_num >= i_den);
    end

    // One shift, compare and subtract per stage.
    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [34:0] n_sh;
        logic        n_ge;
        assign n_sh = {r_rem[k][33:0], 1'b0};
        assign n_ge = (n_sh >= {1'b0, r_den[k]});
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_ge ? (n_sh - {1'b0, r_den[k]}) : n_sh;
            r_den[k+1] <= r_den[k];
            r_q[k+1]   <= {r_q[k][30:0], n_ge};
            r_sat[k+1] <= r_sat[k];
        end
    end

    assign o_q = r_sat[QB] ? QONE : {1'b0, r_q[QB]};
endmodule

/* rtl/core/hb_wprod.sv */
// One lane of the weight product: luminance times tile weight to the seventh power.
// Depends on hb_pkg; five register stages.
module hb_wprod (
    input  logic       i_clk,
    input  hb_pkg::t_q i_lum,
    input  hb_pkg::t_q i_tile,
    output hb_pkg::t_q o_w
);
    import hb_pkg::*;

    t_q r_t1, r_t2, r_t3;
    t_q r_l1, r_l2, r_l3, r_l4;
    t_q r_sq, r_cube, r_six, r_sev, r_w;

    // Power chain t^2, t^3, t^6, t^7, then the luminance product.
    always_ff @(posedge i_clk) begin
        r_sq   <= mulq(i_tile, i_tile);
        r_t1   <= i_tile;
        r_l1   <= i_lum;
        r_cube <= mulq(r_sq, r_t1);
        r_t2   <= r_t1;
        r_l2   <= r_l1;
        r_six  <= mulq(r_cube, r_cube);
        r_t3   <= r_t2;
        r_l3   <= r_l2;
        r_sev  <= mulq(r_six, r_t3);
        r_l4   <= r_l3;
        r_w    <= mulq(r_l4, r_sev);
    end

    assign o_w = r_w;
endmodule

/* rtl/core/hb_gain.sv */
// One lane of the contrast gain in its rational form, followed by its divider.
// Depends on hb_pkg and hb_div; the products are registered ahead of the divider.
module hb_gain (
    input  logic       i_clk,
    input  hb_pkg::t_q i_x,
    input  hb_pkg::t_q i_r,
    output hb_pkg::t_q o_g
);
    import hb_pkg::*;

    logic [33:0] n_two_r, n_two_x, n_num, n_den;
    logic        n_neg;
    t_q          n_sm, n_dist;
    t_q          r_p, r_t;
    logic        r_neg, r_lo;

    // Contrast slope magnitude and twice the distance of x from one half.
    always_comb begin
        n_two_r = {i_r, 1'b0};
        n_two_x = {i_x, 1'b0};
        n_neg   = (n_two_r > {1'b0, QONE});
        n_sm    = n_neg ? 33'(n_two_r - {1'b0, QONE}) : 33'({1'b0, QONE} - n_two_r);
        n_dist  = (i_x < QHALF) ? 33'({1'b0, QONE} - n_two_x)
                                : 33'(n_two_x - {1'b0, QONE});
    end

    // Both products of the gain in one stage.
    always_ff @(posedge i_clk) begin
        r_p   <= mulq(n_sm, n_dist);
        r_t   <= mulq(i_x, i_r);
        r_neg <= n_neg;
        r_lo  <= (i_x < QHALF);
    end

    // Numerator and denominator; a numerator driven below zero gives zero.
    always_comb begin
        if (r_lo) begin
            n_num = {1'b0, r_t};
        end else if (r_neg) begin
            n_num = (r_t > r_p) ? {1'b0, r_t - r_p} : '0;
        end else begin
            n_num = {1'b0, r_t} + {1'b0, r_p};
        end
        n_den = r_neg ? ({1'b0, i_r} - {1'b0, r_p}) : ({1'b0, i_r} + {1'b0, r_p});
    end

    hb_div u_div (
        .i_clk (i_clk),
        .i_num (n_num),
        .i_den (n_den),
        .o_q   (o_g)
    );
endmodule

/* rtl/core/hb_checker.sv */
// Port-level checker for the hextile blend weights block, and its bind.
// Depends on hb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_done,
    input hb_pkg::t_port o_blend_a,
    input hb_pkg::t_port o_blend_b,
    input hb_pkg::t_port o_blend_c,
    input logic          o_degenerate
);
    import hb_pkg::*;

    // A degenerate result carries zero weights.
    `HB_ASSERT_IMP(a_deg_zero, i_clk, i_rst_n, o_done && o_degenerate, (o_blend_a == '0) && (o_blend_b == '0) && (o_blend_c == '0))

    // Every result comes from a request the fixed latency earlier.
    `HB_ASSERT_IMP(a_done_src, i_clk, i_rst_n, o_done, $past(i_start && !o_busy, HB_LAT))

    // Every accepted request yields a result after the fixed latency.
    `HB_ASSERT_IMP(a_req_done, i_clk, i_rst_n, i_start && !o_busy, ##HB_LAT o_done)
endmodule

bind hextile_blend_weights hb_checker u_hb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_done       (o_done),
    .o_blend_a    (o_blend_a),
    .o_blend_b    (o_blend_b),
    .o_blend_c    (o_blend_c),
    .o_degenerate (o_degenerate)
);

/* tb/sv/hextile_blend_weights_tb.sv */
// Self-checking testbench for hextile_blend_weights: directed and random pixels
// under several falloff settings, predicted in Q.32 and compared per result.
// Depends on hb_pkg and the hextile_blend_weights RTL.
module hextile_blend_weights_tb;

    localparam int FB = 16;
    localparam logic [32:0] ONE_Q = 33'h1_0000_0000;
    localparam logic [32:0] HALF_Q = 33'h0_8000_0000;
    localparam logic [32:0] CLAMP_LO = 33'd4294967;
    localparam logic [32:0] CLAMP_HI = 33'd4290672329;
    localparam logic [16:0] FALLOFF_HALF = 17'd32768;

    typedef struct {
        logic [16:0] a;
        logic [16:0] b;
        logic [16:0] c;
        logic        degen;
    } blend_t;

    // Expected blends in request order.
    class blend_board;
        blend_t pending[$];
        int errors;

        function void note(blend_t e);
            pending.push_back(e);
        endfunction

        function void check(blend_t got);
            blend_t e;
            if (pending.size() == 0) begin
                $error("unexpected result a=%0d b=%0d c=%0d", got.a, got.b, got.c);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.a !== e.a) begin
                $error("blend_a expected %0d actual %0d", e.a, got.a);
                errors++;
            end
            if (got.b !== e.b) begin
                $error("blend_b expected %0d actual %0d", e.b, got.b);
                errors++;
            end
            if (got.c !== e.c) begin
                $error("blend_c expected %0d actual %0d", e.c, got.c);
                errors++;
            end
            if (got.degen !== e.degen) begin
                $error("degenerate expected %0d actual %0d", e.degen, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [16:0] i_lum_weight_a = '0, i_lum_weight_b = '0, i_lum_weight_c = '0;
    logic [16:0] i_tile_weight_a = '0, i_tile_weight_b = '0, i_tile_weight_c = '0;
    logic        i_falloff_we = 1'b0;
    logic [16:0] i_falloff = '0;
    logic        o_done;
    logic [16:0] o_blend_a, o_blend_b, o_blend_c;
    logic        o_degenerate;

    logic [16:0] falloff_model;
    int          idle_pct;
    blend_board  board;

    hextile_blend_weights #(.FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_lum_weight_a(i_lum_weight_a), .i_lum_weight_b(i_lum_weight_b),
        .i_lum_weight_c(i_lum_weight_c), .i_tile_weight_a(i_tile_weight_a),
        .i_tile_weight_b(i_tile_weight_b), .i_tile_weight_c(i_tile_weight_c),
        .i_falloff_we(i_falloff_we), .i_falloff(i_falloff), .o_done(o_done),
        .o_blend_a(o_blend_a), .o_blend_b(o_blend_b), .o_blend_c(o_blend_c),
        .o_degenerate(o_degenerate)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Port value to Q.32, saturated to one.
    function automatic logic [32:0] port_to_q(logic [16:0] p);
        logic [32:0] v;
        v = {p, 16'b0};
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

    function automatic logic [32:0] qmul(logic [32:0] x, logic [32:0] y);
        logic [65:0] pr;
        if (x >= ONE_Q) return y;
        if (y >= ONE_Q) return x;
        pr = x * y;
        return pr[64:32];
    endfunction

    // The denominator is a sum of three weights, so it needs the wider type.
    function automatic logic [32:0] qdiv(logic [32:0] num, logic [34:0] den);
        logic [66:0] n;
        if (num >= den) return ONE_Q;
        n = {2'b0, num, 32'b0};
        return 33'(n / den);
    endfunction

    // Contrast gain in the rational form, magnitude products truncated.
    function automatic logic [32:0] contrast_gain(logic [32:0] x, logic [32:0] r);
        logic [34:0] sm, p, t, num, den;
        logic        neg;
        neg = ({r, 1'b0} > ONE_Q);
        sm = neg ? ({r, 1'b0} - ONE_Q) : (ONE_Q - {r, 1'b0});
        t = qmul(x, r);
        if (x < HALF_Q) begin
            p = qmul(sm[32:0], ONE_Q - {x, 1'b0});
            num = t;
        end else begin
            p = qmul(sm[32:0], {x, 1'b0} - ONE_Q);
            num = neg ? ((t > p) ? t - p : 0) : t + p;
        end
        den = neg ? r - p : r + p;
        if (den == 0) return ONE_Q;
        if (num >= den) return ONE_Q;
        return 33'({num, 32'b0} / den);
    endfunction

    function automatic logic [16:0] q_to_port(logic [32:0] v);
        logic [33:0] o;
        o = ({1'b0, v} + 34'h8000) >> 16;
        return (o > 34'h10000) ? 17'h10000 : o[16:0];
    endfunction

    function automatic blend_t predict_blend(logic [16:0] lw[3], logic [16:0] tw[3]);
        logic [32:0] w[3], t, t3, r;
        logic [34:0] s;
        blend_t e;
        for (int i = 0; i < 3; i++) begin
            t = port_to_q(tw[i]);
            t3 = qmul(qmul(t, t), t);
            w[i] = qmul(port_to_q(lw[i]), qmul(qmul(t3, t3), t));
        end
        s = w[0] + w[1] + w[2];
        if (s != 0) begin
            for (int i = 0; i < 3; i++) w[i] = qdiv(w[i], s);
            if (falloff_model != FALLOFF_HALF) begin
                r = {falloff_model, 16'b0};
                if (r < CLAMP_LO) r = CLAMP_LO;
                if (r > CLAMP_HI) r = CLAMP_HI;
                for (int i = 0; i < 3; i++) w[i] = contrast_gain(w[i], r);
                s = w[0] + w[1] + w[2];
                if (s != 0)
                    for (int i = 0; i < 3; i++) w[i] = qdiv(w[i], s);
            end
        end
        if (s == 0) begin
            e.a = 0; e.b = 0; e.c = 0; e.degen = 1'b1;
        end else begin
            e.a = q_to_port(w[0]); e.b = q_to_port(w[1]); e.c = q_to_port(w[2]);
            e.degen = 1'b0;
        end
        return e;
    endfunction

    // Check every result strobe.
    always @(posedge i_clk) begin
        blend_t got;
        if (i_rst_n && o_done) begin
            got.a = o_blend_a; got.b = o_blend_b; got.c = o_blend_c;
            got.degen = o_degenerate;
            board.check(got);
        end
    end

    // Present one request and hold it until accepted; start stays high for the next one.
    task automatic send_pixel(logic [16:0] lw[3], logic [16:0] tw[3]);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_lum_weight_a <= lw[0]; i_lum_weight_b <= lw[1]; i_lum_weight_c <= lw[2];
        i_tile_weight_a <= tw[0]; i_tile_weight_b <= tw[1]; i_tile_weight_c <= tw[2];
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note(predict_blend(lw, tw));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (hb_pkg::HB_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_falloff(logic [16:0] v);
        drain();
        i_falloff_we <= 1'b1;
        i_falloff <= v;
        @(posedge i_clk);
        i_falloff_we <= 1'b0;
        falloff_model = v;
    endtask

    // Random field, biased toward extremes and the range above one.
    function automatic logic [16:0] rand_field();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'h10000;
            2: return 17'($urandom_range(17'h1FFFF, 17'h10001));
            3: return 17'($urandom_range(255));
            default: return 17'($urandom_range(17'h10000));
        endcase
    endfunction

    task automatic random_pixels(int n);
        logic [16:0] lw[3], tw[3];
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 3; i++) begin
                lw[i] = rand_field();
                tw[i] = rand_field();
            end
            if ($urandom_range(19) == 0) tw[$urandom_range(2)] = 0;
            if ($urandom_range(29) == 0) begin
                lw = '{0, 0, 0};
            end
            send_pixel(lw, tw);
        end
    endtask

    initial begin
        logic [16:0] lw[3], tw[3];
        logic [16:0] settings[8];
        int          phases[4];
        board = new();
        falloff_model = FALLOFF_HALF;
        idle_pct = 0;
        settings = '{17'd0, 17'h10000, 17'h1FFFF, 17'd32767, 17'd32769,
                     17'd100, 17'd60000, FALLOFF_HALF};
        phases = '{0, 78, 19, 0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, zero sums, saturation, bypass and gain.
        for (int f = 0; f < 3; f++) begin
            if (f == 1) write_falloff(17'd0);
            if (f == 2) write_falloff(17'h1FFFF);
            lw = '{17'h10000, 17'h10000, 17'h10000}; tw = '{17'h10000, 0, 0};
            send_pixel(lw, tw);
            lw = '{0, 0, 0}; tw = '{17'h10000, 17'h10000, 17'h10000};
            send_pixel(lw, tw);
            lw = '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF}; tw = '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF};
            send_pixel(lw, tw);
            lw = '{17'h10000, 17'h8000, 17'h1}; tw = '{17'h5555, 17'h5555, 17'h5556};
            send_pixel(lw, tw);
            lw = '{17'h10000, 17'h10000, 17'h10000}; tw = '{17'h10, 17'h1, 17'h20};
            send_pixel(lw, tw);
            lw = '{17'h0FFFF, 17'h10000, 17'h0AAAA}; tw = '{17'h8000, 17'h7FFF, 17'h0};
            send_pixel(lw, tw);
        end

        // Random phases across falloff settings and idle patterns.
        for (int s = 0; s < 8; s++) begin
            write_falloff(settings[s]);
            idle_pct = phases[s % 4];
            random_pixels(s == 7 ? 140 : 200);
        end
        write_falloff(17'($urandom_range(17'h1FFFF)));
        idle_pct = 0;
        random_pixels(100);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(64'd20 * 400000);
        $display("Mismatches found");
        $finish;
    end

endmodule
